/* design/rwst_pkg.sv */
// ----------------------------------------------------------------------------
// rwst_pkg
// Shared widths, codes and types for the random walk spanning tree maze block.
// ----------------------------------------------------------------------------
package rwst_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;

  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int DIM_W   = 7;
  localparam int ADDR_W  = COL_W + ROW_W;
  localparam int MAP_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int TOTAL_W = 13;
  localparam int COORD_W = 8;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic             none;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } nbr_t;

  typedef struct packed {
    logic               status;
    logic               opened;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] wall_x;
    logic [COORD_W-1:0] wall_y;
    logic [COL_W-1:0]   walker_column;
    logic [ROW_W-1:0]   walker_row;
    logic               done_res;
  } res_t;

endpackage

/* design/rwst_ram.sv */
// ----------------------------------------------------------------------------
// rwst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rwst_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/rwst_nbr.sv */
// ----------------------------------------------------------------------------
// rwst_nbr
// Neighbor selection: lists existing neighbors up, down, left, right and
// picks entry (pick mod count).
// ----------------------------------------------------------------------------
module rwst_nbr (
  input  logic [rwst_pkg::COL_W-1:0] col,
  input  logic [rwst_pkg::ROW_W-1:0] row,
  input  logic [rwst_pkg::DIM_W-1:0] cols,
  input  logic [rwst_pkg::DIM_W-1:0] rows,
  input  logic [1:0]                 pick,
  output rwst_pkg::nbr_t             nbr
);
  import rwst_pkg::*;

  logic [3:0]       has;
  logic [COL_W-1:0] cand_col [4];
  logic [ROW_W-1:0] cand_row [4];
  logic [2:0]       count;
  logic [1:0]       k;
  logic [1:0]       sel;
  logic [1:0]       n;

  always_comb begin
    has[0] = (row != '0);
    has[1] = (({1'b0, row} + DIM_W'(1)) < rows);
    has[2] = (col != '0);
    has[3] = (({1'b0, col} + DIM_W'(1)) < cols);

    cand_col[0] = col;
    cand_row[0] = row - ROW_W'(1);
    cand_col[1] = col;
    cand_row[1] = row + ROW_W'(1);
    cand_col[2] = col - COL_W'(1);
    cand_row[2] = row;
    cand_col[3] = col + COL_W'(1);
    cand_row[3] = row;

    count = {2'b0, has[0]} + {2'b0, has[1]} + {2'b0, has[2]} + {2'b0, has[3]};

    unique case (count)
      3'd0, 3'd1: k = 2'd0;
      3'd2:       k = {1'b0, pick[0]};
      3'd3:       k = (pick == 2'd3) ? 2'd0 : pick;
      default:    k = pick;
    endcase

    sel = 2'd0;
    n   = 2'd0;
    for (int d = 0; d < 4; d++) begin
      if (has[d]) begin
        if (n == k) begin
          sel = 2'(d);
        end
        n = n + 2'd1;
      end
    end

    nbr.none = (count == 3'd0);
    nbr.col  = cand_col[sel];
    nbr.row  = cand_row[sel];
  end

endmodule

/* design/random_walk_spanning_tree_maze_top.sv */
// ----------------------------------------------------------------------------
// random_walk_spanning_tree_maze_top
// Aldous-Broder random walk over a grid of logical cells, one step per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): req_type 0 starts a walk at
// start_column / start_row, req_type 1 takes one step using pick. Output
// channel (out_valid / out_stall) returns one result per item, in order.
// Config: cfg_we with cfg_index (0 columns, 1 rows) and cfg_data; any write
// ends the current walk.
// Step items: one per cycle sustained while the output is not stalled. The
// walker moves when the item is transferred, the visited bit of the target is
// read from the map RAM and is written back as stage B passes the result on
// to the output register. The read-modify-write overlaps the next step's read,
// which is always a different cell.
// Start items: the map region of columns*rows entries is cleared one entry a
// cycle (the start cell is marked in the same sweep); input stalls meanwhile
// and the result is staged once the last entry is cleared.
// Reset: columns and rows are 1, no walk is active, steps are flagged ignored.
// The map RAM needs no clearing pass after reset.
// A stalled output holds its result; one more result waits in the pipeline
// stage, then in_stall rises.
// ----------------------------------------------------------------------------
module random_walk_spanning_tree_maze_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [5:0]                     start_column,
  input  logic [5:0]                     start_row,
  input  logic [1:0]                     pick,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           status,
  output logic                           opened,
  output logic [7:0]                     cell_x,
  output logic [7:0]                     cell_y,
  output logic [7:0]                     wall_x,
  output logic [7:0]                     wall_y,
  output logic [5:0]                     walker_column,
  output logic [5:0]                     walker_row,
  output logic                           done_res,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [rwst_pkg::DIM_W-1:0]     cfg_data
);
  import rwst_pkg::*;

  state_t state, state_next;

  logic [DIM_W-1:0]   cols_reg, rows_reg;
  logic [DIM_W-1:0]   eff_cols, eff_rows;
  logic [TOTAL_W-1:0] cells;

  logic [COL_W-1:0]   walker_col;
  logic [ROW_W-1:0]   walker_row_reg;
  logic [TOTAL_W-1:0] visited_total;
  logic               walk_active;

  logic [COL_W-1:0]   st_col, clr_col;
  logic [ROW_W-1:0]   st_row, clr_row;
  logic [COL_W-1:0]   sat_col;
  logic [ROW_W-1:0]   sat_row;
  logic               clr_last_col, clr_last;

  logic               s1_valid, s1_look;
  res_t               s1_res;
  logic [COL_W-1:0]   s1_from_col, s1_to_col;
  logic [ROW_W-1:0]   s1_from_row, s1_to_row;
  logic               s1_go, b_inc;
  res_t               b_res;
  logic [TOTAL_W-1:0] total_b;

  logic               out_valid_reg;
  res_t               out_res;

  logic               in_acc, step_ok, done_fwd;
  logic [TOTAL_W-1:0] total_fwd;
  nbr_t               nbr;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [0:0]         ram_wdata, ram_rdata;

  // effective dimensions
  always_comb begin
    if (cols_reg == '0) eff_cols = DIM_W'(1);
    else if (cols_reg > DIM_W'(MAX_COLUMNS)) eff_cols = DIM_W'(MAX_COLUMNS);
    else eff_cols = cols_reg;
    if (rows_reg == '0) eff_rows = DIM_W'(1);
    else if (rows_reg > DIM_W'(MAX_ROWS)) eff_rows = DIM_W'(MAX_ROWS);
    else eff_rows = rows_reg;
    cells = TOTAL_W'(eff_cols) * TOTAL_W'(eff_rows);
  end

  rwst_nbr u_nbr (
    .col  (walker_col),
    .row  (walker_row_reg),
    .cols (eff_cols),
    .rows (eff_rows),
    .pick (pick),
    .nbr  (nbr)
  );

  // stage B: visited bit arrives, finalize result
  assign s1_go   = !out_valid_reg || !out_stall;
  assign b_inc   = s1_valid && s1_look && !ram_rdata[0];
  assign total_b = visited_total + TOTAL_W'(b_inc);

  always_comb begin
    b_res = s1_res;
    if (s1_look) begin
      b_res.status        = STATUS_OK;
      b_res.opened        = !ram_rdata[0];
      b_res.cell_x        = '0;
      b_res.cell_y        = '0;
      b_res.wall_x        = '0;
      b_res.wall_y        = '0;
      b_res.walker_column = s1_to_col;
      b_res.walker_row    = s1_to_row;
      b_res.done_res      = (total_b >= cells);
      if (!ram_rdata[0]) begin
        b_res.cell_x = {1'b0, s1_to_col, 1'b1};
        b_res.cell_y = {1'b0, s1_to_row, 1'b1};
        b_res.wall_x = COORD_W'(s1_from_col) + COORD_W'(s1_to_col) + COORD_W'(1);
        b_res.wall_y = COORD_W'(s1_from_row) + COORD_W'(s1_to_row) + COORD_W'(1);
      end
    end
  end

  // stage A: accept
  assign in_stall  = (state != ST_IDLE) || (s1_valid && !s1_go);
  assign in_acc    = in_valid && !in_stall;
  assign total_fwd = (s1_valid && s1_go) ? total_b : visited_total;
  assign done_fwd  = walk_active && (total_fwd >= cells);
  assign step_ok   = walk_active && !done_fwd && ({1'b0, walker_col} < eff_cols) &&
                     ({1'b0, walker_row_reg} < eff_rows) && !nbr.none;

  assign sat_col = ({1'b0, start_column} >= eff_cols) ? COL_W'(eff_cols - DIM_W'(1))
                                                      : start_column;
  assign sat_row = ({1'b0, start_row} >= eff_rows) ? ROW_W'(eff_rows - DIM_W'(1))
                                                   : start_row;

  assign clr_last_col = ({1'b0, clr_col} == (eff_cols - DIM_W'(1)));
  assign clr_last     = clr_last_col && ({1'b0, clr_row} == (eff_rows - DIM_W'(1)));

  // map RAM ports
  always_comb begin
    ram_re    = in_acc && (req_type == REQ_STEP) && step_ok;
    ram_raddr = {nbr.row, nbr.col};
    if (state == ST_CLEAR) begin
      ram_we       = 1'b1;
      ram_waddr    = {clr_row, clr_col};
      ram_wdata[0] = (clr_col == st_col) && (clr_row == st_row);
    end else begin
      ram_we       = b_inc && s1_go;
      ram_waddr    = {s1_to_row, s1_to_col};
      ram_wdata[0] = 1'b1;
    end
  end

  rwst_ram #(
    .WIDTH (1),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc && (req_type == REQ_START)) state_next = ST_CLEAR;
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_reg       <= DIM_W'(1);
      rows_reg       <= DIM_W'(1);
      walker_col     <= '0;
      walker_row_reg <= '0;
      visited_total  <= '0;
      walk_active    <= 1'b0;
      s1_valid       <= 1'b0;
      out_valid_reg  <= 1'b0;
    end else begin
      if (s1_valid && s1_go) begin
        visited_total <= total_b;
      end
      if (in_acc && (req_type == REQ_STEP) && step_ok) begin
        walker_col     <= nbr.col;
        walker_row_reg <= nbr.row;
      end
      if ((state == ST_CLEAR) && clr_last) begin
        walker_col     <= st_col;
        walker_row_reg <= st_row;
        visited_total  <= TOTAL_W'(1);
        walk_active    <= 1'b1;
      end
      if (cfg_we) begin
        walk_active <= 1'b0;
        unique case (cfg_index)
          CFG_COLUMNS: cols_reg <= cfg_data;
          CFG_ROWS:    rows_reg <= cfg_data;
          default:     ;
        endcase
      end

      if ((in_acc && (req_type == REQ_STEP)) || ((state == ST_CLEAR) && clr_last)) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      if (s1_valid && s1_go) begin
        out_valid_reg <= 1'b1;
      end else if (!out_stall) begin
        out_valid_reg <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc && (req_type == REQ_START)) begin
      st_col  <= sat_col;
      st_row  <= sat_row;
      clr_col <= '0;
      clr_row <= '0;
    end else if (state == ST_CLEAR) begin
      if (clr_last_col) begin
        clr_col <= '0;
        clr_row <= clr_row + ROW_W'(1);
      end else begin
        clr_col <= clr_col + COL_W'(1);
      end
    end

    if (in_acc && (req_type == REQ_STEP)) begin
      s1_look     <= step_ok;
      s1_from_col <= walker_col;
      s1_from_row <= walker_row_reg;
      s1_to_col   <= nbr.col;
      s1_to_row   <= nbr.row;
      s1_res.status        <= STATUS_IGNORED;
      s1_res.opened        <= 1'b0;
      s1_res.cell_x        <= '0;
      s1_res.cell_y        <= '0;
      s1_res.wall_x        <= '0;
      s1_res.wall_y        <= '0;
      s1_res.walker_column <= walker_col;
      s1_res.walker_row    <= walker_row_reg;
      s1_res.done_res      <= done_fwd;
    end else if ((state == ST_CLEAR) && clr_last) begin
      s1_look              <= 1'b0;
      s1_res.status        <= STATUS_OK;
      s1_res.opened        <= 1'b1;
      s1_res.cell_x        <= {1'b0, st_col, 1'b1};
      s1_res.cell_y        <= {1'b0, st_row, 1'b1};
      s1_res.wall_x        <= {1'b0, st_col, 1'b1};
      s1_res.wall_y        <= {1'b0, st_row, 1'b1};
      s1_res.walker_column <= st_col;
      s1_res.walker_row    <= st_row;
      s1_res.done_res      <= (cells == TOTAL_W'(1));
    end

    if (s1_valid && s1_go) begin
      out_res <= b_res;
    end
  end

  assign out_valid     = out_valid_reg;
  assign status        = out_res.status;
  assign opened        = out_res.opened;
  assign cell_x        = out_res.cell_x;
  assign cell_y        = out_res.cell_y;
  assign wall_x        = out_res.wall_x;
  assign wall_y        = out_res.wall_y;
  assign walker_column = out_res.walker_column;
  assign walker_row    = out_res.walker_row;
  assign done_res      = out_res.done_res;

  // read-modify-write never overlaps on one entry
  a_no_rw_same: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("map read and write hit the same entry");

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (in_stall && !ram_re))
    else $error("input taken during clear sweep");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    walk_active |-> (visited_total <= cells))
    else $error("visited count exceeds cell count");

  a_sweep_loads_s1: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_CLEAR) && clr_last) |=> (s1_valid && !s1_look && walk_active))
    else $error("start result not staged after sweep");

endmodule
